[rtl/core/sha256_stream_hasher_top_assert.svh]
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

[rtl/core/sha_pkg.sv]
// ------------------------------------------------------------------------
// sha_pkg
// shared types, constants and the rotate function of the stream hasher
// ------------------------------------------------------------------------
package sha_pkg;
	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} sha_state_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

[rtl/core/sha_queue.sv]
// ------------------------------------------------------------------------
// sha_queue
// short queue of input words between intake and hashing engine
// ------------------------------------------------------------------------
module sha_queue #(
	parameter int unsigned Depth = sha_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  sha_pkg::sha_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output sha_pkg::sha_item_t rd_item,
	output logic               empty
);
	import sha_pkg::*;
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha_item_t          mem_q [Depth];
	logic [AW-1:0]      wptr_q, rptr_q;
	logic [AW:0]        count_q;

	assign full    = (count_q == (AW+1)'(Depth));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en && !full)
				wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			if (rd_en && !empty)
				rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end
endmodule

[rtl/core/sha_engine.sv]
// ------------------------------------------------------------------------
// sha_engine
// message words, schedule, round loop, padding and digest output
// ------------------------------------------------------------------------
module sha_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::sha_item_t item,
	input  logic               item_valid,
	output logic               item_take,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word,
	output logic               out_valid,
	input  logic               out_take
);
	import sha_pkg::*;

	sha_state_t  state_q, state_d;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	// a length block follows the current one
	logic        need2_q;
	// that length block starts with the pad byte
	logic        pad2_q;

	logic [31:0] s0, s1, t1, t2, wn;
	logic [31:0] wload [16];
	logic [31:0] wsecond [16];
	logic [60:0] cnt_n;
	logic [5:0]  fill_n;
	logic        blk_full, need2_n;

	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = s1 + w_q[9] + s0 + w_q[0];
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_q[0];
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign item_take   = (state_q == ST_IDLE) && item_valid;
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && (blk_full || item.end_of_message))
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (need2_q)    state_d = ST_ROUND;
				else if (fin_q) state_d = ST_OUT;
				else            state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (out_take && oidx_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// message words with the incoming byte, pad and length folded in
	always_comb begin
		cnt_n    = count_q + 61'(item.has_byte);
		fill_n   = fill_q + 6'(item.has_byte);
		blk_full = item.has_byte && (fill_q == 6'd63);
		need2_n  = blk_full ? item.end_of_message : (fill_n >= LenPos);
		wload    = w_q;
		if (item.has_byte) begin
			for (int k = 0; k < 4; k++)
				if (fill_q[1:0] == 2'(k)) wload[fill_q[5:2]][31-8*k -: 8] = item.data_byte;
		end
		if (item.end_of_message && !blk_full) begin
			for (int j = 0; j < 16; j++) begin
				for (int k = 0; k < 4; k++) begin
					if (6'(4*j+k) == fill_n)     wload[j][31-8*k -: 8] = PadByte;
					else if (6'(4*j+k) > fill_n) wload[j][31-8*k -: 8] = 8'h00;
				end
			end
			if (fill_n < LenPos) begin
				wload[14] = cnt_n[60:29];
				wload[15] = {cnt_n[28:0], 3'b000};
			end
		end
	end

	// closing block: zeros, pad byte only after a full data block, then length
	always_comb begin
		wsecond[0] = pad2_q ? {PadByte, 24'h000000} : 32'h0;
		for (int j = 1; j < 14; j++) wsecond[j] = 32'h0;
		wsecond[14] = count_q[60:29];
		wsecond[15] = {count_q[28:0], 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
			need2_q <= 1'b0;
			pad2_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= InitH[i];
				v_q[i] <= '0;
			end
			for (int j = 0; j < 16; j++) w_q[j] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (item_take) begin
					fill_q  <= item.end_of_message ? 6'd0 : fill_n;
					count_q <= cnt_n;
					w_q     <= wload;
					if (blk_full || item.end_of_message) begin
						v_q     <= h_q;
						rnd_q   <= '0;
						fin_q   <= item.end_of_message && !need2_n;
						need2_q <= need2_n;
						pad2_q  <= blk_full;
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 1'b1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= '0;
					if (need2_q) begin
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
						w_q     <= wsecond;
						rnd_q   <= '0;
						need2_q <= 1'b0;
						fin_q   <= 1'b1;
					end
				end
				ST_OUT: if (out_take) begin
					oidx_q <= oidx_q + 1'b1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
						count_q <= '0;
						fin_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/core/sha256_stream_hasher_top.sv]
// ------------------------------------------------------------------------
// sha256_stream_hasher_top
// streaming SHA-256 over a byte message
// ------------------------------------------------------------------------
// input side is a queue: push with full low takes one word carrying an
// optional byte (has_byte) and an end_of_message flag
// result side is a queue: while empty is low the digest word, its
// word_index and last_word are shown; pop takes it
// a short queue decouples intake from the hashing engine
// a byte that does not complete a block is only stored and the engine
// stays ready for the next word; a completed block is loaded, runs 64
// rounds and is added into the hash
// end of message costs one or two blocks: the first digest word shows
// once the last block has been added, then eight digest words drain one
// per cycle while pop is high
// a stalled receiver holds the engine in output; intake continues until
// the queue fills
// reset clears the queue, reloads the initial hash and empties outputs
// ------------------------------------------------------------------------
module sha256_stream_hasher_top #(
	parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        push,
	output logic        full,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        empty,
	input  logic        pop
);
	import sha_pkg::*;

	sha_item_t wr_item, rd_item;
	logic      q_empty, take, out_valid;

	assign wr_item = '{data_byte: data_byte, has_byte: has_byte, end_of_message: end_of_message};

	sha_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_en(push), .wr_item, .full,
		.rd_en(take), .rd_item, .empty(q_empty)
	);

	sha_engine u_engine (
		.clk, .arst_n, .item(rd_item), .item_valid(!q_empty), .item_take(take),
		.digest_word, .word_index, .last_word, .out_valid, .out_take(pop)
	);

	assign empty = !out_valid;
endmodule

[rtl/core/sha_checker.sv]
// ------------------------------------------------------------------------
// sha_checker
// port-level checks on the digest output sequence
// ------------------------------------------------------------------------
`include "sha256_stream_hasher_top_assert.svh"
module sha_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [2:0] word_index,
	input logic       last_word,
	input logic       empty,
	input logic       pop
);
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, !empty, last_word == (word_index == 3'd7))
	`SHA_ASSERT_NEXT(a_idx_step, clk, arst_n, !empty && pop && !last_word,
		!empty && word_index == $past(word_index) + 3'd1)
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(word_index))
endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (
	.clk, .arst_n, .word_index, .last_word, .empty, .pop
);
